/* src/ipd_pkg.sv */
// ----------------------------------------------------------------------------
// ipd_pkg
// Shared constants and types for the isolated pixel detector: register
// codes, configuration widths and reset values, and the line store entry.
// ----------------------------------------------------------------------------
package ipd_pkg;

  localparam int DEF_MAX_WIDTH  = 1024;

  localparam int FRAME_WIDTH_W  = 11;
  localparam int FRAME_HEIGHT_W = 16;
  localparam int CFG_DATA_W     = 16;
  localparam int CFG_INDEX_W    = 1;

  localparam logic [CFG_INDEX_W-1:0] CFG_FRAME_WIDTH  = 1'b0;
  localparam logic [CFG_INDEX_W-1:0] CFG_FRAME_HEIGHT = 1'b1;

  localparam logic [FRAME_WIDTH_W-1:0]  FRAME_WIDTH_RST  = 11'd1024;
  localparam logic [FRAME_HEIGHT_W-1:0] FRAME_HEIGHT_RST = 16'd1024;

  // One column of the line store: the row two above and the row just above.
  typedef struct packed {
    logic upper;
    logic lower;
  } ipd_entry_t;

endpackage

/* src/ipd_ram.sv */
// ----------------------------------------------------------------------------
// ipd_ram
// Generic RAM with one write port and two read ports, read data registered.
// ----------------------------------------------------------------------------
module ipd_ram
  import ipd_pkg::*;
#(
  parameter int WIDTH = $bits(ipd_entry_t),
  parameter int DEPTH = DEF_MAX_WIDTH
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr_a,
  output logic [WIDTH-1:0]         rdata_a,
  input  logic [$clog2(DEPTH)-1:0] raddr_b,
  output logic [WIDTH-1:0]         rdata_b
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_a <= mem[raddr_a];
    rdata_b <= mem[raddr_b];
  end

endmodule

/* src/isolated_pixel_detector.sv */
// ----------------------------------------------------------------------------
// isolated_pixel_detector
// Checks a binary raster, streamed in row-major order, for set pixels that
// have no set 4-neighbour, and gives one verdict per frame.
//
// Usage: pixels enter on in_valid / in_stall / in_pixel_set, one request per
// pixel. After the last pixel of a frame one result leaves on out_valid /
// out_stall / out_all_supported (1 when every set pixel has a set neighbour).
// The frame size is written through cfg_valid / cfg_ready / cfg_index /
// cfg_data (index 0 width, index 1 height) while no frame pixel is in flight;
// cfg_ready is always high.
// Throughput is one pixel per cycle. The last pixel of a frame is held off
// while the previous verdict is still stalled in the output register or is
// still in the judge stage, so a single-pixel frame cannot follow another directly.
// The edge that accepts the last pixel loads it into the judge stage (the
// line store read and the judge share that cycle); out_valid rises in the
// next cycle, together with the verdict.
// The line store is one RAM of MAX_WIDTH two-bit entries, read at the current
// and the next column and written back at the current column; a one-entry
// bypass covers very narrow frames and a fill count makes columns never
// written since reset read as clear, so no clearing pass is needed.
// Reset: synchronous, active low; counters return to the frame start and the
// size to 1024 x 1024. A stalled receiver holds the verdict in place.
// ----------------------------------------------------------------------------
module isolated_pixel_detector
  import ipd_pkg::*;
#(
  parameter int MAX_WIDTH = DEF_MAX_WIDTH
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  output logic                   in_stall,
  input  logic                   in_pixel_set,
  output logic                   out_valid,
  input  logic                   out_stall,
  output logic                   out_all_supported,
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data
);

  localparam int COL_W   = $clog2(MAX_WIDTH);
  localparam int CNT_W   = $clog2(MAX_WIDTH + 1);
  localparam int CMP_W   = (CNT_W > FRAME_WIDTH_W) ? CNT_W : FRAME_WIDTH_W;
  localparam int ENTRY_W = $bits(ipd_entry_t);
  localparam logic [CMP_W-1:0] MaxWidthC = CMP_W'(MAX_WIDTH);

  // Configuration
  logic [FRAME_WIDTH_W-1:0]  frame_width_r, frame_width_nxt;
  logic [FRAME_HEIGHT_W-1:0] frame_height_r, frame_height_nxt;

  // Position of the next pixel
  logic [COL_W-1:0]          col_r, col_nxt;
  logic [FRAME_HEIGHT_W-1:0] row_r, row_nxt;

  // Judge stage
  logic                      s1_v_r;
  logic                      s1_pix_r;
  logic [COL_W-1:0]          s1_col_r;
  logic                      s1_r1_r, s1_r2_r;
  logic                      s1_last_col_r, s1_last_row_r;
  logic                      fwd_a_r, fwd_b_r;
  ipd_entry_t                fwd_data_r;
  logic                      vld_a_r, vld_b_r;

  logic [2:0]                win_r, win_nxt;
  logic                      verdict_r, verdict_nxt;
  logic [CNT_W-1:0]          fill_r, fill_nxt;
  logic                      out_valid_r, out_valid_nxt;
  logic                      out_bit_r, out_bit_nxt;

  // Accept-side signals
  logic [CMP_W-1:0]          fw_ext, eff_w, col_ext;
  logic [FRAME_HEIGHT_W-1:0] eff_h;
  logic                      last_col, last_row, in_final, in_acc;
  logic [COL_W-1:0]          c_eff, addr_b;
  logic                      s1_final;

  // Judge-side signals
  logic [ENTRY_W-1:0]        rd_a, rd_b;
  ipd_entry_t                ram_a, ram_b, ent_a, s1_wdata;
  logic                      low_b, above, up2, right_above, b0, b1, b2;
  logic                      fail_up, fail_prev, fail_last;

  assign cfg_ready = 1'b1;

  // ---------------------------------------------------------------- accept
  always_comb begin
    fw_ext = CMP_W'(frame_width_r);
    if (fw_ext == '0) begin
      eff_w = CMP_W'(1);
    end else if (fw_ext > MaxWidthC) begin
      eff_w = MaxWidthC;
    end else begin
      eff_w = fw_ext;
    end
    eff_h    = (frame_height_r == '0) ? FRAME_HEIGHT_W'(1) : frame_height_r;
    col_ext  = CMP_W'(col_r);
    last_col = (col_ext + CMP_W'(1)) >= eff_w;
    // A column beyond a narrowed frame is taken as the last one.
    c_eff    = last_col ? COL_W'(eff_w - CMP_W'(1)) : col_r;
    addr_b   = c_eff + COL_W'(1);
    last_row = row_r >= (eff_h - FRAME_HEIGHT_W'(1));
    in_final = last_col && last_row;
  end

  assign s1_final = s1_v_r && s1_last_col_r && s1_last_row_r;
  // The frame-ending pixel waits until the output register will be free.
  assign in_stall = in_final && (s1_final || (out_valid_r && out_stall));
  assign in_acc   = in_valid && !in_stall;

  always_comb begin
    col_nxt = col_r;
    row_nxt = row_r;
    if (in_acc) begin
      if (last_col) begin
        col_nxt = '0;
        row_nxt = last_row ? '0 : row_r + FRAME_HEIGHT_W'(1);
      end else begin
        col_nxt = c_eff + COL_W'(1);
      end
    end
  end

  always_comb begin
    frame_width_nxt  = frame_width_r;
    frame_height_nxt = frame_height_r;
    if (cfg_valid) begin
      case (cfg_index)
        CFG_FRAME_WIDTH:  frame_width_nxt  = cfg_data[FRAME_WIDTH_W-1:0];
        CFG_FRAME_HEIGHT: frame_height_nxt = cfg_data[FRAME_HEIGHT_W-1:0];
        default: ;
      endcase
    end
  end

  // ------------------------------------------------------------ line store
  ipd_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (MAX_WIDTH)
  ) u_line_store (
    .clk     (clk),
    .we      (s1_v_r),
    .waddr   (s1_col_r),
    .wdata   (s1_wdata),
    .raddr_a (c_eff),
    .rdata_a (rd_a),
    .raddr_b (addr_b),
    .rdata_b (rd_b)
  );

  // ----------------------------------------------------------------- judge
  always_comb begin
    ram_a = ipd_entry_t'(rd_a);
    ram_b = ipd_entry_t'(rd_b);
    // The write of the previous pixel lands on the same edge as this read.
    if (fwd_a_r) begin
      ent_a = fwd_data_r;
    end else if (vld_a_r) begin
      ent_a = ram_a;
    end else begin
      ent_a = '0;
    end
    low_b = fwd_b_r ? fwd_data_r.lower : (vld_b_r & ram_b.lower);

    above       = s1_r1_r & ent_a.lower;
    up2         = s1_r2_r & ent_a.upper;
    right_above = s1_r1_r & ~s1_last_col_r & low_b;
    b0          = s1_r1_r & win_r[0];
    b1          = win_r[1];
    b2          = win_r[2];

    fail_up   = s1_r1_r & above & ~(b0 | right_above | up2 | s1_pix_r);
    fail_prev = s1_last_row_r & (s1_col_r != '0) & b1 & ~(b2 | s1_pix_r | b0);
    fail_last = s1_last_row_r & s1_last_col_r & s1_pix_r & ~(b1 | above);

    s1_wdata.upper = ent_a.lower;
    s1_wdata.lower = s1_pix_r;
  end

  always_comb begin
    verdict_nxt   = verdict_r;
    win_nxt       = win_r;
    fill_nxt      = fill_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_bit_nxt   = out_bit_r;
    if (s1_v_r) begin
      win_nxt = s1_last_col_r ? 3'b000 : {b1, s1_pix_r, above};
      if ((CNT_W'(s1_col_r) + CNT_W'(1)) > fill_r) begin
        fill_nxt = CNT_W'(s1_col_r) + CNT_W'(1);
      end
      if (s1_final) begin
        out_valid_nxt = 1'b1;
        out_bit_nxt   = verdict_r & ~(fail_up | fail_prev | fail_last);
        verdict_nxt   = 1'b1;
      end else begin
        verdict_nxt = verdict_r & ~(fail_up | fail_prev | fail_last);
      end
    end
  end

  // ------------------------------------------------------------- registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frame_width_r  <= FRAME_WIDTH_RST;
      frame_height_r <= FRAME_HEIGHT_RST;
      col_r          <= '0;
      row_r          <= '0;
      s1_v_r         <= 1'b0;
      win_r          <= '0;
      verdict_r      <= 1'b1;
      fill_r         <= '0;
      out_valid_r    <= 1'b0;
    end else begin
      frame_width_r  <= frame_width_nxt;
      frame_height_r <= frame_height_nxt;
      col_r          <= col_nxt;
      row_r          <= row_nxt;
      s1_v_r         <= in_acc;
      win_r          <= win_nxt;
      verdict_r      <= verdict_nxt;
      fill_r         <= fill_nxt;
      out_valid_r    <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_bit_r <= out_bit_nxt;
    if (in_acc) begin
      s1_pix_r      <= in_pixel_set;
      s1_col_r      <= c_eff;
      s1_r1_r       <= row_r != '0;
      s1_r2_r       <= row_r >= FRAME_HEIGHT_W'(2);
      s1_last_col_r <= last_col;
      s1_last_row_r <= last_row;
      fwd_a_r       <= s1_v_r && (s1_col_r == c_eff);
      fwd_b_r       <= s1_v_r && (s1_col_r == addr_b);
      fwd_data_r    <= s1_wdata;
      vld_a_r       <= CNT_W'(c_eff) < fill_r;
      vld_b_r       <= CNT_W'(addr_b) < fill_r;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_all_supported = out_bit_r;

  // ------------------------------------------------------------ assertions
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    s1_final |-> !(out_valid_r && out_stall))
    else $error("verdict would overwrite a stalled result");

  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    fill_r <= CNT_W'(MAX_WIDTH))
    else $error("line store fill count beyond its depth");

  a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(s1_final))
    else $error("result raised without a frame-ending pixel");

  a_forward_source: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_v_r && (fwd_a_r || fwd_b_r)) |-> $past(s1_v_r))
    else $error("bypass taken without a preceding write");

endmodule
